### rtl/fern_pkg.sv
`timescale 1ns / 1ps
package fern_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int CHANCE_W = 7;
  localparam int PPU_W    = 11;
  localparam int ORG_W    = 12;
  localparam int SCREEN_W = 13;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 2;

  localparam int SCREEN_MAX = 4095;
  localparam int SCREEN_MIN = -4096;

  localparam logic [PPU_W-1:0] PPU_RST      = PPU_W'(80);
  localparam logic [ORG_W-1:0] X_ORIGIN_RST = ORG_W'(400);
  localparam logic [ORG_W-1:0] Y_ORIGIN_RST = ORG_W'(600);

  // draw thresholds for the map choice
  localparam logic [CHANCE_W-1:0] CHANCE_STEM     = CHANCE_W'(1);
  localparam logic [CHANCE_W-1:0] CHANCE_LEAF_MAX = CHANCE_W'(85);
  localparam logic [CHANCE_W-1:0] CHANCE_LEFT_MAX = CHANCE_W'(93);

  // depth of the queue between front and back, a power of two
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    MAP_STEM,
    MAP_LEAF,
    MAP_LEFT,
    MAP_RIGHT
  } map_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PPU,
    CFG_X_ORIGIN,
    CFG_Y_ORIGIN
  } cfg_idx_t;

  typedef struct packed {
    logic [PPU_W-1:0] ppu;
    logic [ORG_W-1:0] x_origin;
    logic [ORG_W-1:0] y_origin;
  } cfg_t;

  typedef struct packed {
    logic empty;
    map_t map;
  } qhead_t;

  // coefficient given in hundredths, rounded half away from zero to 2^-frac
  function automatic longint coef(input longint hundredths, input int frac);
    longint mag;
    longint r;
    mag = (hundredths < 0) ? -hundredths : hundredths;
    r = ((mag << frac) + 50) / 100;
    return (hundredths < 0) ? -r : r;
  endfunction

endpackage

### rtl/fern_ifs_point_generator.sv
`timescale 1ns / 1ps
// Barnsley fern point generator. Each beat pushed in carries one random draw
// (nominally 1..100) that selects one of the four fern maps; the block moves its
// internal world point (signed Q5.FRAC_BITS, zero after reset) by that map and
// returns one beat with the screen pixel of the new point and the map index.
// Draws sit in a four-entry queue behind the classifier, so pushes keep being
// taken while the result side is stalled, until the queue is full. Each draw
// then passes in order through the arithmetic back end (coefficient products,
// sum and floor, pixel scaling, result load); that back end, which carries the
// point from one draw to the next, takes no new draw until the result of the
// last one is loaded. Configuration writes (pixels per unit, x origin, y
// origin) are taken at once and should be made only while no draw is in flight.
module fern_ifs_point_generator #(
  parameter int FRAC_BITS = fern_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  input  logic [fern_pkg::CHANCE_W-1:0]        in_chance,
  output logic                                 in_full,
  input  logic                                 out_pop,
  output logic                                 out_empty,
  output logic signed [fern_pkg::SCREEN_W-1:0] out_screen_x,
  output logic signed [fern_pkg::SCREEN_W-1:0] out_screen_y,
  output logic [1:0]                           out_map_index,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fern_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [fern_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import fern_pkg::*;

  cfg_t   cfg_r;
  qhead_t head;
  logic   head_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ppu      <= PPU_RST;
      cfg_r.x_origin <= X_ORIGIN_RST;
      cfg_r.y_origin <= Y_ORIGIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PPU:      cfg_r.ppu      <= cfg_data[PPU_W-1:0];
        CFG_X_ORIGIN: cfg_r.x_origin <= cfg_data[ORG_W-1:0];
        CFG_Y_ORIGIN: cfg_r.y_origin <= cfg_data[ORG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fern_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_chance(in_chance),
    .in_full  (in_full),
    .head_pop (head_pop),
    .head     (head)
  );

  fern_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .head         (head),
    .head_pop     (head_pop),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_screen_x (out_screen_x),
    .out_screen_y (out_screen_y),
    .out_map_index(out_map_index)
  );

endmodule

### rtl/fern_front.sv
`timescale 1ns / 1ps
module fern_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  input  logic [fern_pkg::CHANCE_W-1:0]    in_chance,
  output logic                             in_full,
  input  logic                             head_pop,
  output fern_pkg::qhead_t                 head
);
  import fern_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  map_t             map_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  map_t             map_sel;
  logic             push_ok;
  logic             pop_ok;

  always_comb begin
    priority if (in_chance == CHANCE_STEM) begin
      map_sel = MAP_STEM;
    end else if (in_chance <= CHANCE_LEAF_MAX) begin
      map_sel = MAP_LEAF;
    end else if (in_chance <= CHANCE_LEFT_MAX) begin
      map_sel = MAP_LEFT;
    end else begin
      map_sel = MAP_RIGHT;
    end
  end

  assign in_full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign push_ok    = in_push && !in_full;
  assign pop_ok     = head_pop && (count_r != '0);
  assign head.empty = (count_r == '0);
  assign head.map   = map_q[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      map_q[wr_ptr_r] <= map_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push_ok && !pop_ok) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("accepted beat not counted");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_ok && !push_ok) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("taken beat not removed");
`endif

endmodule

### rtl/fern_back.sv
`timescale 1ns / 1ps
module fern_back #(
  parameter int FRAC_BITS = fern_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fern_pkg::cfg_t                       cfg,
  input  fern_pkg::qhead_t                     head,
  output logic                                 head_pop,
  input  logic                                 out_pop,
  output logic                                 out_empty,
  output logic signed [fern_pkg::SCREEN_W-1:0] out_screen_x,
  output logic signed [fern_pkg::SCREEN_W-1:0] out_screen_y,
  output logic [1:0]                           out_map_index
);
  import fern_pkg::*;

  localparam int W   = FRAC_BITS + 6;   // world point, Q5.FRAC_BITS
  localparam int CW  = FRAC_BITS + 2;   // coefficients, |c| < 2
  localparam int PW  = W + CW;
  localparam int SW  = PW + 2;
  localparam int SP  = W + PPU_W + 1;
  localparam int SSW = SP + 2;

  localparam logic signed [SW-1:0] WORLD_MAX_S = SW'((longint'(1) << (W - 1)) - 1);
  localparam logic signed [SW-1:0] WORLD_MIN_S = -WORLD_MAX_S - SW'(1);
  localparam logic signed [SSW-1:0] SCR_MAX_S  = SSW'(SCREEN_MAX);
  localparam logic signed [SSW-1:0] SCR_MIN_S  = SSW'(SCREEN_MIN);
  localparam logic signed [SSW-1:0] TRUNC_BIAS = SSW'((longint'(1) << FRAC_BITS) - 1);

  localparam logic signed [CW-1:0] K_ZERO    = '0;
  localparam logic signed [CW-1:0] K_STEM_BY = CW'(coef(16, FRAC_BITS));
  localparam logic signed [CW-1:0] K_LEAF_AX = CW'(coef(85, FRAC_BITS));
  localparam logic signed [CW-1:0] K_LEAF_BX = CW'(coef(4, FRAC_BITS));
  localparam logic signed [CW-1:0] K_LEAF_AY = CW'(coef(-4, FRAC_BITS));
  localparam logic signed [CW-1:0] K_LEAF_BY = CW'(coef(85, FRAC_BITS));
  localparam logic signed [CW-1:0] K_LEAF_OY = CW'(coef(160, FRAC_BITS));
  localparam logic signed [CW-1:0] K_LEFT_AX = CW'(coef(20, FRAC_BITS));
  localparam logic signed [CW-1:0] K_LEFT_BX = CW'(coef(-26, FRAC_BITS));
  localparam logic signed [CW-1:0] K_LEFT_AY = CW'(coef(23, FRAC_BITS));
  localparam logic signed [CW-1:0] K_LEFT_BY = CW'(coef(22, FRAC_BITS));
  localparam logic signed [CW-1:0] K_LEFT_OY = CW'(coef(160, FRAC_BITS));
  localparam logic signed [CW-1:0] K_RGHT_AX = CW'(coef(-15, FRAC_BITS));
  localparam logic signed [CW-1:0] K_RGHT_BX = CW'(coef(28, FRAC_BITS));
  localparam logic signed [CW-1:0] K_RGHT_AY = CW'(coef(26, FRAC_BITS));
  localparam logic signed [CW-1:0] K_RGHT_BY = CW'(coef(24, FRAC_BITS));
  localparam logic signed [CW-1:0] K_RGHT_OY = CW'(coef(44, FRAC_BITS));

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_SCALE,
    S_OUT
  } state_t;

  state_t                      state_r;
  map_t                        map_r;
  logic signed [W-1:0]         world_x_r;
  logic signed [W-1:0]         world_y_r;
  logic signed [PW-1:0]        pxa_r, pxb_r, pya_r, pyb_r;
  logic signed [CW-1:0]        oy_r;
  logic signed [SP-1:0]        sxp_r, syp_r;
  logic                        out_valid_r;
  logic signed [SCREEN_W-1:0]  screen_x_r, screen_y_r;
  map_t                        out_map_r;

  logic signed [CW-1:0]        ax, bx, ay, by, oy;
  logic signed [SW-1:0]        sum_x, sum_y, fl_x, fl_y;
  logic signed [W-1:0]         world_x_nxt, world_y_nxt;
  logic signed [PPU_W:0]       ppu_s;
  logic signed [ORG_W:0]       xo_s, yo_s;
  logic signed [SSW-1:0]       sxn, syn, sxt, syt;
  logic signed [SCREEN_W-1:0]  screen_x_nxt, screen_y_nxt;
  logic                        out_load;

  // map coefficients; every x offset is zero
  always_comb begin
    unique case (head.map)
      MAP_STEM: begin
        ax = K_ZERO;    bx = K_ZERO;    ay = K_ZERO;    by = K_STEM_BY; oy = K_ZERO;
      end
      MAP_LEAF: begin
        ax = K_LEAF_AX; bx = K_LEAF_BX; ay = K_LEAF_AY; by = K_LEAF_BY; oy = K_LEAF_OY;
      end
      MAP_LEFT: begin
        ax = K_LEFT_AX; bx = K_LEFT_BX; ay = K_LEFT_AY; by = K_LEFT_BY; oy = K_LEFT_OY;
      end
      MAP_RIGHT: begin
        ax = K_RGHT_AX; bx = K_RGHT_BX; ay = K_RGHT_AY; by = K_RGHT_BY; oy = K_RGHT_OY;
      end
    endcase
  end

  // floor to the world grid, then clamp
  always_comb begin
    sum_x = SW'(pxa_r) + SW'(pxb_r);
    sum_y = SW'(pya_r) + SW'(pyb_r) + (SW'(oy_r) <<< FRAC_BITS);
    fl_x  = sum_x >>> FRAC_BITS;
    fl_y  = sum_y >>> FRAC_BITS;
    if (fl_x > WORLD_MAX_S) begin
      world_x_nxt = WORLD_MAX_S[W-1:0];
    end else if (fl_x < WORLD_MIN_S) begin
      world_x_nxt = WORLD_MIN_S[W-1:0];
    end else begin
      world_x_nxt = fl_x[W-1:0];
    end
    if (fl_y > WORLD_MAX_S) begin
      world_y_nxt = WORLD_MAX_S[W-1:0];
    end else if (fl_y < WORLD_MIN_S) begin
      world_y_nxt = WORLD_MIN_S[W-1:0];
    end else begin
      world_y_nxt = fl_y[W-1:0];
    end
  end

  assign ppu_s = $signed({1'b0, cfg.ppu});
  assign xo_s  = $signed({1'b0, cfg.x_origin});
  assign yo_s  = $signed({1'b0, cfg.y_origin});

  // screen position, truncated toward zero, then clamped
  always_comb begin
    sxn = SSW'(sxp_r) + (SSW'(xo_s) <<< FRAC_BITS);
    syn = (SSW'(yo_s) <<< FRAC_BITS) - SSW'(syp_r);
    sxt = (sxn + (sxn[SSW-1] ? TRUNC_BIAS : SSW'(0))) >>> FRAC_BITS;
    syt = (syn + (syn[SSW-1] ? TRUNC_BIAS : SSW'(0))) >>> FRAC_BITS;
    if (sxt > SCR_MAX_S) begin
      screen_x_nxt = SCR_MAX_S[SCREEN_W-1:0];
    end else if (sxt < SCR_MIN_S) begin
      screen_x_nxt = SCR_MIN_S[SCREEN_W-1:0];
    end else begin
      screen_x_nxt = sxt[SCREEN_W-1:0];
    end
    if (syt > SCR_MAX_S) begin
      screen_y_nxt = SCR_MAX_S[SCREEN_W-1:0];
    end else if (syt < SCR_MIN_S) begin
      screen_y_nxt = SCR_MIN_S[SCREEN_W-1:0];
    end else begin
      screen_y_nxt = syt[SCREEN_W-1:0];
    end
  end

  assign head_pop = (state_r == S_IDLE) && !head.empty;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      world_x_r   <= '0;
      world_y_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_pop && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!head.empty) begin
            map_r   <= head.map;
            pxa_r   <= PW'(ax) * PW'(world_x_r);
            pxb_r   <= PW'(bx) * PW'(world_y_r);
            pya_r   <= PW'(ay) * PW'(world_x_r);
            pyb_r   <= PW'(by) * PW'(world_y_r);
            oy_r    <= oy;
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          world_x_r <= world_x_nxt;
          world_y_r <= world_y_nxt;
          state_r   <= S_SCALE;
        end
        S_SCALE: begin
          sxp_r   <= SP'(world_x_r) * SP'(ppu_s);
          syp_r   <= SP'(world_y_r) * SP'(ppu_s);
          state_r <= S_OUT;
        end
        S_OUT: begin
          // wait here while the previous result is still held
          if (out_load) begin
            screen_x_r  <= screen_x_nxt;
            screen_y_r  <= screen_y_nxt;
            out_map_r   <= map_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_empty     = !out_valid_r;
  assign out_screen_x  = screen_x_r;
  assign out_screen_y  = screen_y_r;
  assign out_map_index = out_map_r;

`ifndef SYNTHESIS
  a_world_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SUM) |=> ($stable(world_x_r) && $stable(world_y_r)))
    else $error("world point moved outside the update step");

  a_stem_zero_x: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM && map_r == MAP_STEM) |=> (world_x_r == '0))
    else $error("stem map left a nonzero x");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |=> (state_r == S_SUM))
    else $error("queue head taken without starting an update");
`endif

endmodule
